// ----- src/iou_dbf_pkg.sv -----
`timescale 1ns / 1ps

package iou_dbf_pkg;

  // Fixed field widths of the item and result formats.
  localparam int COORD_BITS = 12;
  localparam int THR_W      = 9;
  localparam int IOU_FRAC   = 8;
  localparam int SLOT_W     = 4;
  localparam int COUNT_W    = 5;

  // Derived arithmetic widths.
  localparam int AREA_W = 2 * COORD_BITS;
  localparam int UNI_W  = AREA_W + 1;
  localparam int PROD_W = THR_W + UNI_W;

  localparam logic [THR_W-1:0] THR_RESET = THR_W'(128);

  // Item kinds.
  localparam logic KIND_START = 1'b0;
  localparam logic KIND_BOX   = 1'b1;

  typedef struct packed {
    logic                  kind;
    logic [COORD_BITS-1:0] box_x;
    logic [COORD_BITS-1:0] box_y;
    logic [COORD_BITS-1:0] box_w;
    logic [COORD_BITS-1:0] box_h;
  } in_item_t;

  typedef struct packed {
    logic               kept;
    logic [SLOT_W-1:0]  slot;
    logic               overflow;
    logic [COUNT_W-1:0] kept_count;
  } out_item_t;

  typedef struct packed {
    logic [COORD_BITS-1:0] x;
    logic [COORD_BITS-1:0] y;
    logic [COORD_BITS-1:0] w;
    logic [COORD_BITS-1:0] h;
  } box_t;

  // Controller to datapath commands.
  typedef struct packed {
    logic load;
    logic rd_en;
    logic wr_en;
    logic flush;
  } dp_cmd_t;

  // Datapath to controller status.
  typedef struct packed {
    logic busy;
    logic hit;
  } dp_status_t;

endpackage

// ----- src/iou_duplicate_box_filter_unit.sv -----
`timescale 1ns / 1ps

// Channel   Direction  Handshake             Payload
// in_       input      in_valid / in_stall   in_item_t (kind, box_x, box_y, box_w, box_h)
// out_      output     out_valid / out_stall out_item_t (kept, slot, overflow, kept_count)
// cfg_      input      cfg_wr_en             cfg_wr_data (iou_threshold, 9 bits)
//
// A start item passes through ST_RESULT before the next item is accepted.
// A box item passes through ST_SETUP and ST_SCAN to ST_RESULT; the scan ends at the
// first match in store order or after all kept boxes: one compare per cycle
// enters a five-stage compare pipeline, which drains before the append.
// Reset (rst_n low, synchronous) empties the store and sets the threshold to 128.
// A result held by out_stall waits in the output register; the next item is still accepted.

module iou_duplicate_box_filter_unit import iou_dbf_pkg::*; #(
  parameter int MAX_BOXES = 16
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_stall,
  input  in_item_t         in_item,
  output logic             out_valid,
  input  logic             out_stall,
  output out_item_t        out_item,
  input  logic             cfg_wr_en,
  input  logic [THR_W-1:0] cfg_wr_data
);

  localparam int AW = $clog2(MAX_BOXES);

  dp_cmd_t       cmd;
  dp_status_t    status;
  logic [AW-1:0] rd_addr;
  logic [AW-1:0] wr_addr;
  logic [AW-1:0] hit_idx;

  // Sequencer for scan, append and result.
  iou_dbf_ctrl #(
    .MAX_BOXES (MAX_BOXES)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_kind   (in_item.kind),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_item),
    .cmd       (cmd),
    .rd_addr   (rd_addr),
    .wr_addr   (wr_addr),
    .status    (status),
    .hit_idx   (hit_idx)
  );

  // Box store and overlap compare pipeline.
  iou_dbf_dp #(
    .MAX_BOXES (MAX_BOXES)
  ) u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_item     (in_item),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .cmd         (cmd),
    .rd_addr     (rd_addr),
    .wr_addr     (wr_addr),
    .status      (status),
    .hit_idx     (hit_idx)
  );

endmodule

// ----- src/iou_dbf_dp.sv -----
`timescale 1ns / 1ps

module iou_dbf_dp import iou_dbf_pkg::*; #(
  parameter int MAX_BOXES = 16,
  localparam int AW = $clog2(MAX_BOXES)
) (
  input  logic              clk,
  input  logic              rst_n,
  input  in_item_t          in_item,
  input  logic              cfg_wr_en,
  input  logic [THR_W-1:0]  cfg_wr_data,
  input  dp_cmd_t           cmd,
  input  logic [AW-1:0]     rd_addr,
  input  logic [AW-1:0]     wr_addr,
  output dp_status_t        status,
  output logic [AW-1:0]     hit_idx
);

  localparam int CB = COORD_BITS;

  // Kept-box store, one read and one write port.
  box_t kept_boxes_r [MAX_BOXES];

  logic [THR_W-1:0]  thr_r;
  box_t              box_r;
  logic [AREA_W-1:0] pa_r;

  // Pipeline stage registers.
  logic              v0_r, v1_r, v2_r, v3_r, v4_r;
  logic [AW-1:0]     idx0_r, idx1_r, idx2_r, idx3_r, idx4_r;
  box_t              q0_r;
  logic [CB-1:0]     iw1_r, ih1_r;
  logic [AREA_W-1:0] qa1_r, qa2_r;
  logic [AREA_W-1:0] inter2_r, inter3_r;
  logic [UNI_W-1:0]  uni3_r;
  logic              hit4_r;

  // Overlap edges of the offered box against the stored box.
  logic [CB-1:0] left, top;
  logic [CB:0]   p_right, p_bottom, q_right, q_bottom, right, bottom;
  logic [PROD_W-1:0] lhs, rhs;

  always_comb begin
    left     = (box_r.x > q0_r.x) ? box_r.x : q0_r.x;
    top      = (box_r.y > q0_r.y) ? box_r.y : q0_r.y;
    p_right  = {1'b0, box_r.x} + {1'b0, box_r.w};
    p_bottom = {1'b0, box_r.y} + {1'b0, box_r.h};
    q_right  = {1'b0, q0_r.x} + {1'b0, q0_r.w};
    q_bottom = {1'b0, q0_r.y} + {1'b0, q0_r.h};
    right    = (p_right < q_right) ? p_right : q_right;
    bottom   = (p_bottom < q_bottom) ? p_bottom : q_bottom;
  end

  // Duplicate test: inter * 256 > threshold * union.
  assign lhs = PROD_W'({inter3_r, IOU_FRAC'(0)});
  assign rhs = PROD_W'(thr_r) * PROD_W'(uni3_r);

  // Threshold register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thr_r <= THR_RESET;
    end else if (cfg_wr_en) begin
      thr_r <= cfg_wr_data;
    end
  end

  // Offered box and its area.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      box_r.x <= in_item.box_x;
      box_r.y <= in_item.box_y;
      box_r.w <= in_item.box_w;
      box_r.h <= in_item.box_h;
    end
    pa_r <= AREA_W'(box_r.w) * AREA_W'(box_r.h);
  end

  // Store write and registered read.
  always_ff @(posedge clk) begin
    if (cmd.wr_en) begin
      kept_boxes_r[wr_addr] <= box_r;
    end
    if (cmd.rd_en) begin
      q0_r   <= kept_boxes_r[rd_addr];
      idx0_r <= rd_addr;
    end
  end

  // Valid bits of the compare pipeline.
  always_ff @(posedge clk) begin
    if (!rst_n || cmd.flush) begin
      v0_r <= 1'b0;
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
    end else begin
      v0_r <= cmd.rd_en;
      v1_r <= v0_r;
      v2_r <= v1_r;
      v3_r <= v2_r;
      v4_r <= v3_r;
    end
  end

  // Compare pipeline payload.
  always_ff @(posedge clk) begin
    // Intersection extents and stored area.
    iw1_r  <= (right > {1'b0, left}) ? CB'(right - {1'b0, left}) : '0;
    ih1_r  <= (bottom > {1'b0, top}) ? CB'(bottom - {1'b0, top}) : '0;
    qa1_r  <= AREA_W'(q0_r.w) * AREA_W'(q0_r.h);
    idx1_r <= idx0_r;
    // Intersection area.
    inter2_r <= AREA_W'(iw1_r) * AREA_W'(ih1_r);
    qa2_r    <= qa1_r;
    idx2_r   <= idx1_r;
    // Union area.
    uni3_r   <= {1'b0, pa_r} + {1'b0, qa2_r} - {1'b0, inter2_r};
    inter3_r <= inter2_r;
    idx3_r   <= idx2_r;
    // Threshold decision; a zero union never matches.
    hit4_r <= (uni3_r != '0) && (lhs > rhs);
    idx4_r <= idx3_r;
  end

  assign status.busy = v0_r | v1_r | v2_r | v3_r | v4_r;
  assign status.hit  = v4_r & hit4_r;
  assign hit_idx     = idx4_r;

endmodule

// ----- src/iou_dbf_ctrl.sv -----
`timescale 1ns / 1ps

module iou_dbf_ctrl import iou_dbf_pkg::*; #(
  parameter int MAX_BOXES = 16,
  localparam int AW = $clog2(MAX_BOXES),
  localparam int CW = $clog2(MAX_BOXES + 1)
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_stall,
  input  logic          in_kind,
  output logic          out_valid,
  input  logic          out_stall,
  output out_item_t     out_item,
  output dp_cmd_t       cmd,
  output logic [AW-1:0] rd_addr,
  output logic [AW-1:0] wr_addr,
  input  dp_status_t    status,
  input  logic [AW-1:0] hit_idx
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SETUP,
    ST_SCAN,
    ST_RESULT
  } state_t;

  state_t    state_r, state_nxt;
  logic [CW-1:0] count_r, count_nxt;
  logic [CW-1:0] issue_r, issue_nxt;
  out_item_t res_r, res_nxt;
  out_item_t out_item_r, out_item_nxt;
  logic      out_valid_r, out_valid_nxt;

  // Next-state and command logic.
  always_comb begin
    state_nxt     = state_r;
    count_nxt     = count_r;
    issue_nxt     = issue_r;
    res_nxt       = res_r;
    out_valid_nxt = out_valid_r & out_stall;
    out_item_nxt  = out_item_r;
    cmd           = '0;
    rd_addr       = issue_r[AW-1:0];
    wr_addr       = count_r[AW-1:0];

    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.load = 1'b1;
          if (in_kind == KIND_START) begin
            count_nxt = '0;
            res_nxt   = '0;
            state_nxt = ST_RESULT;
          end else begin
            issue_nxt = '0;
            state_nxt = ST_SETUP;
          end
        end
      end

      // Box area settles in the datapath.
      ST_SETUP: begin
        state_nxt = ST_SCAN;
      end

      ST_SCAN: begin
        if (status.hit) begin
          // First matching kept box, in store order.
          cmd.flush           = 1'b1;
          res_nxt.kept        = 1'b0;
          res_nxt.slot        = SLOT_W'(hit_idx);
          res_nxt.overflow    = 1'b0;
          res_nxt.kept_count  = COUNT_W'(count_r);
          state_nxt           = ST_RESULT;
        end else if (issue_r == count_r && !status.busy) begin
          // No match: append if there is room.
          res_nxt = '0;
          if (count_r < CW'(MAX_BOXES)) begin
            cmd.wr_en    = 1'b1;
            count_nxt    = count_r + 1'b1;
            res_nxt.kept = 1'b1;
            res_nxt.slot = SLOT_W'(count_r);
          end else begin
            res_nxt.overflow = 1'b1;
          end
          res_nxt.kept_count = COUNT_W'(count_nxt);
          state_nxt          = ST_RESULT;
        end else if (issue_r != count_r) begin
          cmd.rd_en = 1'b1;
          issue_nxt = issue_r + 1'b1;
        end
      end

      ST_RESULT: begin
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt = 1'b1;
          out_item_nxt  = res_r;
          state_nxt     = ST_IDLE;
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // State, counters and output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      count_r     <= '0;
      issue_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      issue_r     <= issue_nxt;
      out_valid_r <= out_valid_nxt;
      res_r       <= res_nxt;
      out_item_r  <= out_item_nxt;
    end
  end

  assign in_stall  = (state_r != ST_IDLE);
  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

endmodule
